[design/can_signal_extract_defines.svh]
// ----------------------------------------------------------------------------
// CAN signal extractor assertion macros
// Shared property forms for the checks in the signal extractor.
// ----------------------------------------------------------------------------
`ifndef CAN_SIGNAL_EXTRACT_DEFINES_SVH
`define CAN_SIGNAL_EXTRACT_DEFINES_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define CSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define CSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cse_pkg.sv]
// ----------------------------------------------------------------------------
// CAN signal extractor package
// Item types, control bundle and constants shared by the extractor modules.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 8;
  localparam int unsigned FRAME_BYTES_MAX   = 8;
  localparam int unsigned LE_WINDOW_BYTES   = 5;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned VALUE_W           = 32;
  localparam int unsigned ACC_W             = LE_WINDOW_BYTES * BYTE_W;

  typedef struct packed {
    logic [63:0] payload;
    logic [5:0]  start_bit;
    logic [5:0]  length;
    logic        little_endian;
    logic        is_signed;
  } cse_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] signal_value;
    logic               out_of_frame;
  } cse_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } cse_state_t;

  typedef struct packed {
    logic       load;
    logic       shift;
    logic [3:0] byte_idx;
    logic [2:0] shamt;
    logic [5:0] length;
    logic       is_signed;
    logic       oof;
  } cse_ctl_t;

endpackage

[design/cse_seq.sv]
// ----------------------------------------------------------------------------
// CAN signal extractor byte sequencer
// Works out the byte walk of a signal and steps through it one byte a cycle.
// ----------------------------------------------------------------------------
module cse_seq import cse_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cse_item_t item,
  input  logic      item_valid,
  input  logic      out_free,
  output logic      busy,
  output logic      finish,
  output cse_ctl_t  ctl
);

  localparam int unsigned FrameBytes =
    (PAYLOAD_BYTES > FRAME_BYTES_MAX) ? FRAME_BYTES_MAX : PAYLOAD_BYTES;

  cse_state_t state;
  cse_state_t state_next;
  logic [3:0] idx;
  logic [3:0] cnt;
  logic       down;
  logic [2:0] shamt;
  logic [5:0] len;
  logic       sgn;
  logic       oof;

  logic [2:0] blk;
  logic [2:0] ofs;
  logic       len_nz;
  logic [6:0] base;
  logic [6:0] last;
  logic [3:0] last_byte;
  logic       load;

  assign blk       = item.start_bit[5:3];
  assign ofs       = item.start_bit[2:0];
  assign len_nz    = (item.length != 6'd0);
  assign base      = item.little_endian ? {1'b0, item.start_bit} : {1'b0, blk, ~ofs};
  assign last      = len_nz ? (base + {1'b0, item.length} - 7'd1) : base;
  assign last_byte = last[6:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      down  <= item.little_endian;
      idx   <= item.little_endian ? ({1'b0, blk} + 4'(LE_WINDOW_BYTES - 1)) : {1'b0, blk};
      cnt   <= item.little_endian ? 4'(LE_WINDOW_BYTES) : (last_byte - {1'b0, blk} + 4'd1);
      shamt <= item.little_endian ? ofs : ~last[2:0];
      len   <= item.length;
      sgn   <= item.is_signed;
      oof   <= len_nz && (last_byte >= 4'(FrameBytes));
    end else if (state == ST_RUN) begin
      idx <= down ? (idx - 4'd1) : (idx + 4'd1);
      cnt <= cnt - 4'd1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt == 4'd1) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    load          = (state == ST_IDLE) && item_valid;
    busy          = (state != ST_IDLE);
    finish        = (state == ST_DONE) && out_free;
    ctl.load      = load;
    ctl.shift     = (state == ST_RUN);
    ctl.byte_idx  = idx;
    ctl.shamt     = shamt;
    ctl.length    = len;
    ctl.is_signed = sgn;
    ctl.oof       = oof;
  end

endmodule

[design/cse_gather.sv]
// ----------------------------------------------------------------------------
// CAN signal extractor byte gatherer
// Shifts the walked bytes into an accumulator, then aligns, masks and
// sign-extends the signal value.
// ----------------------------------------------------------------------------
module cse_gather import cse_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  cse_ctl_t    ctl,
  input  logic [63:0] payload,
  output cse_result_t result
);

  localparam int unsigned FrameBytes =
    (PAYLOAD_BYTES > FRAME_BYTES_MAX) ? FRAME_BYTES_MAX : PAYLOAD_BYTES;

  logic [63:0]        pay;
  logic [ACC_W-1:0]   acc;
  logic [BYTE_W-1:0]  cur_byte;
  logic [ACC_W-1:0]   shifted;
  logic [VALUE_W-1:0] mask;
  logic [VALUE_W-1:0] masked;
  logic               sign_bit;
  logic               extend;

  assign cur_byte = (ctl.byte_idx < 4'(FrameBytes)) ?
                    pay[{ctl.byte_idx[2:0], 3'b000} +: BYTE_W] : '0;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pay <= payload;
      acc <= '0;
    end else if (ctl.shift) begin
      acc <= {acc[ACC_W-BYTE_W-1:0], cur_byte};
    end
  end

  always_comb begin
    shifted  = acc >> ctl.shamt;
    mask     = ctl.length[5] ? '1 : ~({VALUE_W{1'b1}} << ctl.length[4:0]);
    masked   = shifted[VALUE_W-1:0] & mask;
    sign_bit = masked[5'(ctl.length - 6'd1)];
    extend   = ctl.is_signed && (ctl.length != 6'd0) && !ctl.length[5] && sign_bit;
    result.signal_value = extend ? (masked | ~mask) : masked;
    result.out_of_frame = ctl.oof;
  end

endmodule

[design/can_signal_extract.sv]
// ----------------------------------------------------------------------------
// CAN signal extractor top level
// Flow: the sequencer walks the bytes of an accepted item, the result is registered once the output is free.
// Throughput: item_stall holds off a new item until the sequencer is back in idle; result stalls delay that.
// Reset: synchronous rst empties the result register and idles the sequencer.
// ----------------------------------------------------------------------------
`include "can_signal_extract_defines.svh"

module can_signal_extract import cse_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cse_item_t   item,
  input  logic        item_valid,
  output logic        item_stall,
  output cse_result_t result,
  output logic        result_valid,
  input  logic        result_stall
);

  cse_ctl_t    ctl;
  cse_result_t res_c;
  logic        busy;
  logic        finish;
  logic        out_free;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = busy;

  cse_seq #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .item_valid(item_valid),
    .out_free  (out_free),
    .busy      (busy),
    .finish    (finish),
    .ctl       (ctl)
  );

  cse_gather #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_gather (
    .clk    (clk),
    .ctl    (ctl),
    .payload(item.payload),
    .result (res_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result <= res_c;
    end
  end

  `CSE_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "not busy")
  `CSE_ASSERT_NOW(a_no_overwrite, finish, !(result_valid && result_stall), "result overwritten")
  `CSE_ASSERT_NOW(a_empty_signal, finish && (ctl.length == 6'd0), res_c == '0, "empty nonzero")

endmodule

[sim/tb_can_signal_extract.sv]
// ----------------------------------------------------------------------------
// CAN signal extractor testbench
// Sends payload and signal descriptor items through the extractor, with random
// gaps on the input side and random stalls on the result side. It predicts the
// signal value and the out of frame flag of every accepted item and checks each
// result in order.
// ----------------------------------------------------------------------------
module tb_can_signal_extract;
  import cse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_LIMIT = (PAYLOAD_BYTES_DEF > FRAME_BYTES_MAX) ?
                                        FRAME_BYTES_MAX : PAYLOAD_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned IDLE_PERCENT = 12;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  cse_item_t   item = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  cse_result_t result;
  logic        result_valid;
  logic        result_stall = 1'b0;

  cse_item_t   pending_items[$];
  cse_result_t expected_results[$];
  int unsigned items_taken = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic        no_idle;

  can_signal_extract #(.PAYLOAD_BYTES(PAYLOAD_BYTES_DEF)) u_top (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  always #2 clk = ~clk;

  assign no_idle = (items_taken >= 400) && (items_taken < 650);

  function automatic cse_result_t extract_signal(cse_item_t it);
    cse_result_t res;
    logic [31:0] val;
    logic [31:0] mask;
    logic        oof;
    logic        b;
    int unsigned pos;
    int unsigned byte_no;
    int unsigned off;
    int unsigned n;
    val = '0;
    oof = 1'b0;
    if (it.little_endian) begin
      for (n = 0; n < it.length; n++) begin
        pos = it.start_bit + n;
        byte_no = pos >> 3;
        off = pos & 7;
        if (byte_no >= FRAME_LIMIT) begin
          oof = 1'b1;
        end else if (n < 32) begin
          val[n] = it.payload[byte_no * 8 + off];
        end
      end
    end else begin
      byte_no = it.start_bit >> 3;
      off = it.start_bit & 7;
      for (n = 0; n < it.length; n++) begin
        b = 1'b0;
        if (byte_no >= FRAME_LIMIT) begin
          oof = 1'b1;
        end else begin
          b = it.payload[byte_no * 8 + off];
        end
        val = {val[30:0], b};
        if (off == 0) begin
          byte_no++;
          off = 7;
        end else begin
          off--;
        end
      end
    end
    if (it.is_signed && it.length >= 1 && it.length < 32) begin
      mask = (32'h1 << it.length) - 32'h1;
      val &= mask;
      if (val[it.length - 1]) begin
        val |= ~mask;
      end
    end
    res.signal_value = val;
    res.out_of_frame = oof;
    return res;
  endfunction

  function automatic cse_item_t make_item(logic [63:0] payload, int unsigned start,
                                          int unsigned len, bit le, bit sgn);
    cse_item_t it;
    it.payload = payload;
    it.start_bit = 6'(start);
    it.length = 6'(len);
    it.little_endian = le;
    it.is_signed = sgn;
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_results.push_back(extract_signal(item));
        items_taken++;
      end
      if (!item_valid || !item_stall) begin
        if (pending_items.size() > 0 &&
            (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cse_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: signal_value=%h out_of_frame=%b",
                   $time, result.signal_value, result.out_of_frame);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (result.signal_value !== want.signal_value) begin
            $display("%0t: signal_value expected %h actual %h",
                     $time, want.signal_value, result.signal_value);
            mismatches++;
          end
          if (result.out_of_frame !== want.out_of_frame) begin
            $display("%0t: out_of_frame expected %b actual %b",
                     $time, want.out_of_frame, result.out_of_frame);
            mismatches++;
          end
        end
      end
      result_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned k;
    int unsigned sel;
    int unsigned len;
    logic [63:0] payload;

    pending_items.push_back(make_item('1, 0, 32, 1'b1, 1'b0));
    pending_items.push_back(make_item(64'h1, 0, 1, 1'b1, 1'b1));
    pending_items.push_back(make_item(64'hA5, 7, 8, 1'b0, 1'b0));
    pending_items.push_back(make_item(64'h0123_4567_89AB_CDEF, 7, 32, 1'b0, 1'b1));
    pending_items.push_back(make_item(64'h8000_0000_0000_0000, 63, 1, 1'b1, 1'b1));
    pending_items.push_back(make_item('1, 60, 8, 1'b1, 1'b0));
    pending_items.push_back(make_item('1, 56, 16, 1'b0, 1'b1));
    pending_items.push_back(make_item(64'h1, 0, 1, 1'b0, 1'b0));
    pending_items.push_back(make_item('1, 63, 32, 1'b0, 1'b0));
    pending_items.push_back(make_item('1, 12, 0, 1'b1, 1'b1));
    pending_items.push_back(make_item('1, 12, 0, 1'b0, 1'b1));
    pending_items.push_back(make_item('1, 0, 33, 1'b1, 1'b1));
    pending_items.push_back(make_item('1, 7, 63, 1'b0, 1'b1));
    pending_items.push_back(make_item(64'h4000_0000, 0, 31, 1'b1, 1'b1));
    pending_items.push_back(make_item(64'h3FFF_FFFF, 0, 31, 1'b1, 1'b1));
    pending_items.push_back(make_item('0, 7, 32, 1'b0, 1'b1));
    pending_items.push_back(make_item('1, 31, 32, 1'b1, 1'b1));
    pending_items.push_back(make_item(64'h0180, 0, 2, 1'b0, 1'b1));
    pending_items.push_back(make_item(64'h0180, 7, 2, 1'b1, 1'b0));
    pending_items.push_back(make_item('1, 39, 32, 1'b0, 1'b1));
    pending_items.push_back(make_item(64'hFF00_0000_0000_0000, 56, 8, 1'b0, 1'b1));

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      sel = $urandom_range(99);
      if (sel < 1) begin
        len = 0;
      end else if (sel < 5) begin
        len = $urandom_range(63, 33);
      end else begin
        len = $urandom_range(32, 1);
      end
      payload = {$urandom, $urandom};
      pending_items.push_back(make_item(payload, $urandom_range(63), len,
                                        1'($urandom_range(1)), 1'($urandom_range(1))));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
